@@ hdl/sorted_key_set_table_core_assert.svh @@
// ---------------------------------------------------------------------------
// sorted_key_set_table_core_assert.svh
// Assertion macros used by the sorted key set table RTL (skst_ctrl).
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_SET_TABLE_CORE_ASSERT_SVH
`define SORTED_KEY_SET_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define SKST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define SKST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/skst_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skst_pkg
// Types and constants of the sorted key set table.
// ---------------------------------------------------------------------------
package skst_pkg;

  // Table geometry
  localparam int CAPACITY    = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // Port field widths
  localparam int FUNC_W      = 3;
  localparam int KEY_FIELD_W = 32;
  localparam int POS_W       = 6;
  localparam int STATUS_W    = 3;
  localparam int RIDX_W      = 7;
  localparam int RCNT_W      = 7;

  // Request codes
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT    = 3'd0,
    FN_FIND      = 3'd1,
    FN_ERASE_KEY = 3'd2,
    FN_ERASE_IDX = 3'd3,
    FN_READ_IDX  = 3'd4,
    FN_LOWER     = 3'd5,
    FN_UPPER     = 3'd6,
    FN_CLEAR     = 3'd7
  } skst_func_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_RANGE   = 3'd4
  } skst_status_e;

  // Memory request from the sequencer
  typedef struct packed {
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;
  } skst_mem_req_t;

  // Result word of one request
  typedef struct packed {
    skst_status_e         status;
    logic [CNT_W-1:0]     index;
    logic [KEY_WIDTH-1:0] key;
    logic [CNT_W-1:0]     count;
  } skst_res_t;

endpackage

@@ hdl/sorted_key_set_table_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_key_set_table_core
// Sorted set of unique keys with binary search, insert, erase and bounds.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Fields
//  request   in         in_valid_i / in_stall_o    func, key, position
//  result    out        out_valid_o / out_stall_i  status, result_index,
//                                                  result_key, entry_count
//
//  One request at a time. A binary search probes the key memory (up to 7
//  probes), each probe a read then a compare, then reads the entry at the bound.
//  Insert and erase move one entry per cycle through the read/write ports of
//  the key memory. Clear goes straight to the result.
//  Reset clears the count only; key memory content is not cleared.
//  A stalled result waits in the output register while the next word is taken.
// ---------------------------------------------------------------------------
module sorted_key_set_table_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [skst_pkg::FUNC_W-1:0]        func_i,
  input  logic [skst_pkg::KEY_FIELD_W-1:0]   key_i,
  input  logic [skst_pkg::POS_W-1:0]         position_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [skst_pkg::STATUS_W-1:0]      status_o,
  output logic [skst_pkg::RIDX_W-1:0]        result_index_o,
  output logic [skst_pkg::KEY_FIELD_W-1:0]   result_key_o,
  output logic [skst_pkg::RCNT_W-1:0]        entry_count_o
);

  import skst_pkg::*;

  logic                 in_ready;
  skst_mem_req_t        mem_req;
  logic [KEY_WIDTH-1:0] rd_data;
  logic                 res_valid;
  logic                 res_take;
  skst_res_t            res;

  logic                 out_valid_q;
  skst_res_t            out_q;

  assign in_stall_o = !in_ready;

  skst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready),
    .func_i     (func_i),
    .key_i      (key_i[KEY_WIDTH-1:0]),
    .position_i (position_i),
    .mem_req_o  (mem_req),
    .rd_data_i  (rd_data),
    .res_valid_o(res_valid),
    .res_take_i (res_take),
    .res_o      (res)
  );

  skst_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(KEY_WIDTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (mem_req.wr_en),
    .wr_addr_i(mem_req.wr_addr),
    .wr_data_i(mem_req.wr_data),
    .rd_en_i  (mem_req.rd_en),
    .rd_addr_i(mem_req.rd_addr),
    .rd_data_o(rd_data)
  );

  // Load the output register when it is empty or being drained
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  // Drive the result word
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign result_index_o = RIDX_W'(out_q.index);
  assign result_key_o   = KEY_FIELD_W'(out_q.key);
  assign entry_count_o  = RCNT_W'(out_q.count);

endmodule

@@ hdl/skst_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skst_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module skst_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

@@ hdl/skst_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skst_ctrl
// Request sequencer: binary search, probe and shift over the key memory.
// ---------------------------------------------------------------------------
`include "sorted_key_set_table_core_assert.svh"

module skst_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request word
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [skst_pkg::FUNC_W-1:0]      func_i,
  input  logic [skst_pkg::KEY_WIDTH-1:0]   key_i,
  input  logic [skst_pkg::POS_W-1:0]       position_i,
  // key memory
  output skst_pkg::skst_mem_req_t          mem_req_o,
  input  logic [skst_pkg::KEY_WIDTH-1:0]   rd_data_i,
  // result word
  output logic                             res_valid_o,
  input  logic                             res_take_i,
  output skst_pkg::skst_res_t              res_o
);

  import skst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_SWAIT,
    S_PROBE,
    S_EVAL,
    S_SHIFT,
    S_RESP
  } state_e;

  state_e               state_q, state_d;
  skst_func_e           func_q, func_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [CNT_W-1:0]     lo_q, lo_d;
  logic [CNT_W-1:0]     hi_q, hi_d;
  logic [IDX_W-1:0]     mid_q, mid_d;
  logic [CNT_W-1:0]     ridx_q, ridx_d;
  logic                 inr_q, inr_d;
  logic [KEY_WIDTH-1:0] e_q, e_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [IDX_W-1:0]     cur_q, cur_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic                 pend_q, pend_d;
  logic [IDX_W-1:0]     wdst_q, wdst_d;
  logic                 up_q, up_d;
  skst_status_e         st_q, st_d;
  logic [KEY_WIDTH-1:0] rkey_q, rkey_d;

  logic                 in_fire;
  logic [CNT_W:0]       mid_sum;
  logic [CNT_W-1:0]     pos_ext;
  logic                 go_right;
  logic                 hit;
  logic                 erase_ok;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign pos_ext    = CNT_W'(position_i);
  assign go_right   = (func_q == FN_UPPER) ? (rd_data_i <= key_q) : (rd_data_i < key_q);
  assign hit        = inr_q && (e_q == key_q);
  assign erase_ok   = (func_q == FN_ERASE_KEY) ? hit : inr_q;

  // Next-state and memory request logic
  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    key_d     = key_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    ridx_d    = ridx_q;
    inr_d     = inr_q;
    e_d       = e_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    rem_d     = rem_q;
    pend_d    = pend_q;
    wdst_d    = wdst_q;
    up_d      = up_q;
    st_d      = st_q;
    rkey_d    = rkey_q;
    mem_req_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          func_d = skst_func_e'(func_i);
          key_d  = key_i;
          unique case (skst_func_e'(func_i))
            FN_CLEAR: begin
              cnt_d   = '0;
              st_d    = ST_OK;
              ridx_d  = '0;
              rkey_d  = '0;
              state_d = S_RESP;
            end
            FN_ERASE_IDX, FN_READ_IDX: begin
              ridx_d = pos_ext;
              inr_d  = (pos_ext < cnt_q);
              if (pos_ext < cnt_q) begin
                mem_req_o.rd_en   = 1'b1;
                mem_req_o.rd_addr = position_i;
                state_d           = S_PROBE;
              end else begin
                state_d = S_EVAL;
              end
            end
            default: begin
              lo_d    = '0;
              hi_d    = cnt_q;
              state_d = S_SRCH;
            end
          endcase
        end
      end

      // Halve the window, or settle on the bound and probe it if it is inside the table
      S_SRCH: begin
        if (lo_q < hi_q) begin
          mid_d             = mid_sum[IDX_W:1];
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = mid_sum[IDX_W:1];
          state_d           = S_SWAIT;
        end else begin
          ridx_d = lo_q;
          inr_d  = (lo_q < cnt_q);
          if (lo_q < cnt_q) begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = lo_q[IDX_W-1:0];
            state_d           = S_PROBE;
          end else begin
            state_d = S_EVAL;
          end
        end
      end

      S_SWAIT: begin
        if (go_right) begin
          lo_d = CNT_W'(mid_q) + CNT_W'(1);
        end else begin
          hi_d = CNT_W'(mid_q);
        end
        state_d = S_SRCH;
      end

      S_PROBE: begin
        e_d     = rd_data_i;
        state_d = S_EVAL;
      end

      // Decide status and whether the table moves
      S_EVAL: begin
        st_d    = ST_OK;
        rkey_d  = '0;
        state_d = S_RESP;
        unique case (func_q)
          FN_INSERT: begin
            if (hit) begin
              st_d   = ST_PRESENT;
              rkey_d = e_q;
            end else if (cnt_q >= CNT_W'(CAPACITY)) begin
              st_d = ST_FULL;
            end else begin
              rem_d   = cnt_q - ridx_q;
              cur_d   = cnt_q[IDX_W-1:0];
              pend_d  = 1'b0;
              up_d    = 1'b1;
              state_d = S_SHIFT;
            end
          end
          FN_FIND: begin
            if (hit) begin
              rkey_d = e_q;
            end else begin
              st_d = ST_ABSENT;
            end
          end
          FN_ERASE_KEY, FN_ERASE_IDX: begin
            if (erase_ok) begin
              rkey_d  = e_q;
              rem_d   = cnt_q - ridx_q - CNT_W'(1);
              cur_d   = ridx_q[IDX_W-1:0];
              pend_d  = 1'b0;
              up_d    = 1'b0;
              state_d = S_SHIFT;
            end else begin
              st_d = (func_q == FN_ERASE_KEY) ? ST_ABSENT : ST_RANGE;
            end
          end
          FN_READ_IDX: begin
            if (inr_q) begin
              rkey_d = e_q;
            end else begin
              st_d = ST_RANGE;
            end
          end
          FN_LOWER, FN_UPPER: begin
            rkey_d = inr_q ? e_q : '0;
          end
          FN_CLEAR: begin
            rkey_d = '0;
          end
        endcase
      end

      // Move one entry per cycle; read and write never hit the same entry
      S_SHIFT: begin
        if (pend_q) begin
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = wdst_q;
          mem_req_o.wr_data = rd_data_i;
        end
        if (rem_q != '0) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = up_q ? (cur_q - IDX_W'(1)) : (cur_q + IDX_W'(1));
          pend_d            = 1'b1;
          wdst_d            = cur_q;
          cur_d             = up_q ? (cur_q - IDX_W'(1)) : (cur_q + IDX_W'(1));
          rem_d             = rem_q - CNT_W'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (up_q) begin
              mem_req_o.wr_en   = 1'b1;
              mem_req_o.wr_addr = ridx_q[IDX_W-1:0];
              mem_req_o.wr_data = key_q;
              cnt_d             = cnt_q + CNT_W'(1);
            end else begin
              cnt_d = cnt_q - CNT_W'(1);
            end
            state_d = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      func_q  <= FN_INSERT;
      key_q   <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      mid_q   <= '0;
      ridx_q  <= '0;
      inr_q   <= 1'b0;
      e_q     <= '0;
      cnt_q   <= '0;
      cur_q   <= '0;
      rem_q   <= '0;
      pend_q  <= 1'b0;
      wdst_q  <= '0;
      up_q    <= 1'b0;
      st_q    <= ST_OK;
      rkey_q  <= '0;
    end else begin
      state_q <= state_d;
      func_q  <= func_d;
      key_q   <= key_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      mid_q   <= mid_d;
      ridx_q  <= ridx_d;
      inr_q   <= inr_d;
      e_q     <= e_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
      rem_q   <= rem_d;
      pend_q  <= pend_d;
      wdst_q  <= wdst_d;
      up_q    <= up_d;
      st_q    <= st_d;
      rkey_q  <= rkey_d;
    end
  end

  // Present the result word
  assign res_valid_o  = (state_q == S_RESP);
  assign res_o.status = st_q;
  assign res_o.index  = ridx_q;
  assign res_o.key    = rkey_q;
  assign res_o.count  = cnt_q;

  `SKST_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= CNT_W'(CAPACITY), "count above capacity")
  `SKST_ASSERT_NOW(a_no_write_idle, (state_q == S_IDLE) || (state_q == S_RESP), !mem_req_o.wr_en, "memory written outside a request")
  `SKST_ASSERT_NOW(a_range_index, res_valid_o && (res_o.status == ST_RANGE), res_o.index >= res_o.count, "range status with index inside table")
  `SKST_ASSERT_NOW(a_full_count, res_valid_o && (res_o.status == ST_FULL), res_o.count == CNT_W'(CAPACITY), "full status with room left")
  `SKST_ASSERT_NEXT(a_accept_busy, in_fire, state_q != S_IDLE, "accepted word did not start work")

endmodule

@@ test/skst_result_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skst_result_checker
// Watches both channels of the sorted key set table and checks each result
// word against a sorted-array model updated by every accepted request.
// ---------------------------------------------------------------------------
module skst_result_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_o,
  input  logic [skst_pkg::FUNC_W-1:0]      func_i,
  input  logic [skst_pkg::KEY_FIELD_W-1:0] key_i,
  input  logic [skst_pkg::POS_W-1:0]       position_i,
  input  logic                             out_valid_o,
  input  logic                             out_stall_i,
  input  logic [skst_pkg::STATUS_W-1:0]    status_o,
  input  logic [skst_pkg::RIDX_W-1:0]      result_index_o,
  input  logic [skst_pkg::KEY_FIELD_W-1:0] result_key_o,
  input  logic [skst_pkg::RCNT_W-1:0]      entry_count_o,
  output int                               fail_count_o,
  output int                               pending_o
);
  import skst_pkg::*;

  typedef struct packed {
    skst_status_e            status;
    logic [RIDX_W-1:0]       index;
    logic [KEY_FIELD_W-1:0]  key;
    logic [RCNT_W-1:0]       count;
  } skst_outcome_t;

  // Shadow copy of the table
  logic [KEY_WIDTH-1:0] table_keys [CAPACITY];
  int unsigned          table_count = 0;

  skst_outcome_t pending_results [$];
  skst_outcome_t due_word;
  skst_outcome_t seen_word;
  skst_outcome_t fresh_word;
  bit            word_bad;
  int            failures = 0;
  int            waiting  = 0;

  assign fail_count_o = failures;
  assign pending_o    = waiting;

  // First entry not below k, or first entry above k when past_equal is set
  function automatic int unsigned bound_of(logic [KEY_WIDTH-1:0] k, bit past_equal);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = table_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (past_equal ? (table_keys[mid] <= k) : (table_keys[mid] < k)) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Close the gap left by an erased entry
  function automatic void drop_entry(int unsigned at);
    int unsigned i;
    for (i = at; i + 1 < table_count; i++) table_keys[i] = table_keys[i + 1];
    table_count--;
  endfunction

  // Apply one request to the shadow table and work out its result word
  task automatic apply_request(input skst_func_e fn, input logic [KEY_FIELD_W-1:0] k_in,
                               input logic [POS_W-1:0] pos, output skst_outcome_t res);
    logic [KEY_WIDTH-1:0] k;
    int unsigned          idx;
    int unsigned          i;
    skst_status_e         st;
    logic [KEY_WIDTH-1:0] found;
    k     = k_in[KEY_WIDTH-1:0];
    idx   = 0;
    st    = ST_OK;
    found = '0;
    case (fn)
      FN_INSERT: begin
        idx = bound_of(k, 1'b0);
        if (idx < table_count && table_keys[idx] == k) begin
          st    = ST_PRESENT;
          found = table_keys[idx];
        end else if (table_count >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          for (i = table_count; i > idx; i--) table_keys[i] = table_keys[i - 1];
          table_keys[idx] = k;
          table_count++;
        end
      end
      FN_FIND, FN_ERASE_KEY: begin
        idx = bound_of(k, 1'b0);
        if (idx < table_count && table_keys[idx] == k) begin
          found = table_keys[idx];
          if (fn == FN_ERASE_KEY) drop_entry(idx);
        end else begin
          st = ST_ABSENT;
        end
      end
      FN_ERASE_IDX, FN_READ_IDX: begin
        idx = pos;
        if (pos < table_count) begin
          found = table_keys[pos];
          if (fn == FN_ERASE_IDX) drop_entry(pos);
        end else begin
          st = ST_RANGE;
        end
      end
      FN_LOWER, FN_UPPER: begin
        idx = bound_of(k, fn == FN_UPPER);
        if (idx < table_count) found = table_keys[idx];
      end
      default: begin
        table_count = 0;
      end
    endcase
    res.status = st;
    res.index  = idx[RIDX_W-1:0];
    res.key    = KEY_FIELD_W'(found);
    res.count  = table_count[RCNT_W-1:0];
  endtask

  // Retire the result word first, then queue the prediction for a new request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_count = 0;
      pending_results.delete();
      waiting = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result word with no request outstanding");
          failures++;
        end else begin
          due_word         = pending_results.pop_front();
          seen_word.status = skst_status_e'(status_o);
          seen_word.index  = result_index_o;
          seen_word.key    = result_key_o;
          seen_word.count  = entry_count_o;
          word_bad         = 1'b0;
          if (seen_word.status !== due_word.status) begin
            $error("status expected %0d actual %0d", due_word.status, seen_word.status);
            word_bad = 1'b1;
          end
          if (seen_word.index !== due_word.index) begin
            $error("result_index expected %0d actual %0d", due_word.index, seen_word.index);
            word_bad = 1'b1;
          end
          if (seen_word.key !== due_word.key) begin
            $error("result_key expected %h actual %h", due_word.key, seen_word.key);
            word_bad = 1'b1;
          end
          if (seen_word.count !== due_word.count) begin
            $error("entry_count expected %0d actual %0d", due_word.count, seen_word.count);
            word_bad = 1'b1;
          end
          if (word_bad) failures++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        apply_request(skst_func_e'(func_i), key_i, position_i, fresh_word);
        pending_results.push_back(fresh_word);
      end
      waiting = pending_results.size();
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives directed and randomized table requests into the sorted key set
// table, with random gaps and stalls, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb;
  import skst_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_OFF   = 300;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [FUNC_W-1:0]      func_i;
  logic [KEY_FIELD_W-1:0] key_i;
  logic [POS_W-1:0]       position_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [STATUS_W-1:0]    status_o;
  logic [RIDX_W-1:0]      result_index_o;
  logic [KEY_FIELD_W-1:0] result_key_o;
  logic [RCNT_W-1:0]      entry_count_o;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit steady = 1'b0;
  bit hold_off_req = 1'b0;

  sorted_key_set_table_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .key_i          (key_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .result_index_o (result_index_o),
    .result_key_o   (result_key_o),
    .entry_count_o  (entry_count_o)
  );

  skst_result_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .key_i          (key_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .result_index_o (result_index_o),
    .result_key_o   (result_key_o),
    .entry_count_o  (entry_count_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Abort when neither channel moves a word for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request word after a random gap and hold it until taken
  task automatic send_word(input skst_func_e fn, input logic [KEY_FIELD_W-1:0] k,
                           input logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    func_i     <= fn;
    key_i      <= k;
    position_i <= pos;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop offering and wait until every result word has come back
  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
  endtask

  function automatic skst_func_e pick_func(int unsigned ins_pct, int unsigned clr_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < clr_pct) return FN_CLEAR;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return FN_INSERT;
    case ($urandom_range(0, 5))
      0:       return FN_FIND;
      1:       return FN_ERASE_KEY;
      2:       return FN_ERASE_IDX;
      3:       return FN_READ_IDX;
      4:       return FN_LOWER;
      default: return FN_UPPER;
    endcase
  endfunction

  // Key pools: near zero, near the top, a scattered set that can fill the table, anything
  function automatic logic [KEY_FIELD_W-1:0] pick_key(int unsigned pool);
    case (pool)
      0:       return KEY_FIELD_W'($urandom_range(0, 23));
      1:       return 32'hFFFF_FFFF - KEY_FIELD_W'($urandom_range(0, 23));
      2:       return 32'h0300_0001 * KEY_FIELD_W'($urandom_range(0, 90));
      default: return KEY_FIELD_W'($urandom());
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position;
    if ($urandom_range(0, 1) == 0) return POS_W'($urandom_range(0, 63));
    return POS_W'($urandom_range(0, 7));
  endfunction

  // Receiver: random stall per word, with one long hold-off on request
  initial begin
    int unsigned lag;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        lag = HOLD_OFF;
      end else begin
        lag = steady ? 0 : $urandom_range(0, 4);
      end
      repeat (lag) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned items;
    int unsigned pool;
    int unsigned ins_pct;
    int unsigned clr_pct;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    func_i     = FN_CLEAR;
    key_i      = '0;
    position_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, extreme keys, duplicates, misses, bounds past the end
    send_word(FN_CLEAR,     32'h0000_0000, 6'd0);
    send_word(FN_FIND,      32'h0000_0000, 6'd0);
    send_word(FN_READ_IDX,  32'h0000_0000, 6'd0);
    send_word(FN_ERASE_IDX, 32'h0000_0000, 6'd63);
    send_word(FN_LOWER,     32'h0000_0000, 6'd0);
    send_word(FN_UPPER,     32'hFFFF_FFFF, 6'd0);
    send_word(FN_INSERT,    32'h8000_0000, 6'd0);
    send_word(FN_INSERT,    32'h0000_0000, 6'd0);
    send_word(FN_INSERT,    32'hFFFF_FFFF, 6'd0);
    send_word(FN_INSERT,    32'h8000_0000, 6'd0);
    send_word(FN_FIND,      32'hFFFF_FFFF, 6'd0);
    send_word(FN_FIND,      32'h0000_0005, 6'd0);
    send_word(FN_LOWER,     32'h7FFF_FFFF, 6'd0);
    send_word(FN_UPPER,     32'h8000_0000, 6'd0);
    send_word(FN_UPPER,     32'hFFFF_FFFF, 6'd0);
    send_word(FN_LOWER,     32'h8000_0000, 6'd0);
    send_word(FN_READ_IDX,  32'h0000_0000, 6'd2);
    send_word(FN_READ_IDX,  32'h0000_0000, 6'd63);
    send_word(FN_ERASE_KEY, 32'h0000_0000, 6'd0);
    send_word(FN_ERASE_KEY, 32'h0000_0000, 6'd0);
    send_word(FN_ERASE_IDX, 32'h0000_0000, 6'd0);
    send_word(FN_ERASE_IDX, 32'h0000_0000, 6'd5);
    send_word(FN_INSERT,    32'h5555_5555, 6'd0);
    send_word(FN_CLEAR,     32'h0000_0000, 6'd0);
    send_word(FN_INSERT,    32'hAAAA_AAAA, 6'd0);
    drain();

    // Random phases; phase 2 fills the table and opens with a long receiver hold-off
    for (phase = 0; phase < 8; phase++) begin
      items   = 100;
      pool    = phase % 4;
      ins_pct = 40;
      clr_pct = 3;
      steady  = (phase == 3 || phase == 5);
      case (phase)
        2: begin
          items   = 150;
          ins_pct = 90;
          clr_pct = 0;
          hold_off_req = 1'b1;
        end
        3: clr_pct = 0;
        6: begin
          pool    = 2;
          ins_pct = 60;
          clr_pct = 1;
        end
        7: pool = 1;
        default: ;
      endcase
      for (n = 0; n < items; n++) begin
        send_word(pick_func(ins_pct, clr_pct), pick_key(pool), pick_position());
      end
      drain();
    end

    // Let the block settle, then report
    steady = 1'b0;
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sorted_key_set_table_core.f @@
+incdir+hdl
hdl/skst_pkg.sv
hdl/skst_ram.sv
hdl/skst_ctrl.sv
hdl/sorted_key_set_table_core.sv
test/skst_result_checker.sv
test/tb.sv
